FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the clock gate tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: hdl/rcgt_pkg.sv
// Package with the constants, types and helpers of the clock gate tracker.
`timescale 1ns / 1ps

package rcgt_pkg;

  localparam int NUM_BUSES       = 5;
  localparam int DOMAINS_PER_BUS = 32;
  localparam int COUNT_WIDTH     = 8;
  localparam int NUM_REGS        = 5;

  localparam int BUS_W    = 3;
  localparam int MASK_W   = 32;
  localparam int DOM_W    = 6;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int BUS_AW   = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
  localparam int REG_AW   = 3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_BUS   = 3'd1,
    ERR_RANGE = 3'd2,
    ERR_OVER  = 3'd3,
    ERR_UNDER = 3'd4
  } err_code_t;

  typedef logic [DOMAINS_PER_BUS-1:0][COUNT_WIDTH-1:0] count_row_t;

  typedef struct packed {
    logic [BUS_W-1:0]  bus_select;
    logic [MASK_W-1:0] domain_mask;
    logic              direction;
  } in_word_t;

  typedef struct packed {
    logic [BUS_W-1:0]  bus_echo;
    logic [MASK_W-1:0] clock_enable_mask;
    err_code_t         error_code;
  } out_word_t;

  // Mask of the peripheral bits that a bus with the given count may use.
  function automatic logic [MASK_W-1:0] valid_mask(input logic [DOM_W-1:0] count);
    logic [DOM_W-1:0]  n;
    logic [MASK_W-1:0] m;
    n = (count > DOM_W'(DOMAINS_PER_BUS)) ? DOM_W'(DOMAINS_PER_BUS) : count;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (DOM_W'(i) < n) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

FILE: hdl/refcounted_clock_gate_tracker_unit.sv
// Top level of the reference-counted clock gate tracker.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The accept edge reads the bus's row of demand counters from the counter
// memory, and the following cycle updates the counters of that row selected
// by the domain mask in parallel and, if no error is found, writes the row
// back. The result word is strobed on out_strobe in the cycle after that, for
// one cycle only, and busy is already low then, so a new request can be taken
// while that result is strobed. The counter memory has one read-modify-write
// port. Counters read as zero after reset through one valid bit per bus row,
// so no clearing pass is needed. Configuration writes should be made only
// while busy is low and no result is pending.
module refcounted_clock_gate_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rcgt_pkg::in_word_t               in_word,
  output logic                             out_strobe,
  output rcgt_pkg::out_word_t              out_word,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcgt_pkg::PADDR_W-1:0]     paddr,
  input  logic [rcgt_pkg::PDATA_W-1:0]     pwdata,
  output logic [rcgt_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RMW  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [rcgt_pkg::DOM_W-1:0] domains_r [rcgt_pkg::NUM_REGS];
  logic [rcgt_pkg::REG_AW-1:0] reg_idx;

  rcgt_pkg::count_row_t mem [rcgt_pkg::NUM_BUSES];
  rcgt_pkg::count_row_t rd_row_r;
  logic [rcgt_pkg::NUM_BUSES-1:0] row_valid_r;

  rcgt_pkg::in_word_t req_r;
  logic               accept;
  logic               bus_ok_in;
  logic               bus_ok;
  logic [rcgt_pkg::BUS_AW-1:0] row_idx;

  rcgt_pkg::count_row_t  cur_row;
  rcgt_pkg::count_row_t  new_row;
  logic                  over;
  logic                  under;
  logic [rcgt_pkg::DOM_W-1:0]  bus_count;
  logic [rcgt_pkg::MASK_W-1:0] bus_valid;
  logic [rcgt_pkg::MASK_W-1:0] en_mask;
  rcgt_pkg::err_code_t   err;
  logic                  mem_we;

  logic                  out_strobe_r;
  rcgt_pkg::out_word_t   out_word_r;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[rcgt_pkg::PADDR_W-1:2];

  always_comb begin
    prdata = '0;
    if (reg_idx < rcgt_pkg::REG_AW'(rcgt_pkg::NUM_REGS)) begin
      prdata = rcgt_pkg::PDATA_W'(domains_r[reg_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rcgt_pkg::NUM_REGS; k++) begin
        domains_r[k] <= rcgt_pkg::DOM_W'(32);
      end
    end else if (psel && penable && pwrite &&
                 reg_idx < rcgt_pkg::REG_AW'(rcgt_pkg::NUM_REGS)) begin
      domains_r[reg_idx] <= pwdata[rcgt_pkg::DOM_W-1:0];
    end
  end

  // Control
  assign busy      = (state_r == ST_RMW);
  assign accept    = start && !busy;
  assign bus_ok_in = (in_word.bus_select < rcgt_pkg::BUS_W'(rcgt_pkg::NUM_BUSES));
  assign bus_ok    = (req_r.bus_select < rcgt_pkg::BUS_W'(rcgt_pkg::NUM_BUSES));
  assign row_idx   = req_r.bus_select[rcgt_pkg::BUS_AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RMW;
      ST_RMW:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_word;
    end
  end

  // Counter memory: one row of counters per bus, read at accept, written
  // back in the update cycle if no error is found.
  always_ff @(posedge clk) begin
    if (accept && bus_ok_in) begin
      rd_row_r <= mem[in_word.bus_select[rcgt_pkg::BUS_AW-1:0]];
    end
    if (mem_we) begin
      mem[row_idx] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (mem_we) begin
      row_valid_r[row_idx] <= 1'b1;
    end
  end

  // Update of one row
  always_comb begin
    cur_row = '0;
    if (bus_ok && row_valid_r[row_idx]) begin
      cur_row = rd_row_r;
    end
    over    = 1'b0;
    under   = 1'b0;
    new_row = cur_row;
    for (int i = 0; i < rcgt_pkg::DOMAINS_PER_BUS; i++) begin
      if (req_r.domain_mask[i]) begin
        if (!req_r.direction && cur_row[i] == rcgt_pkg::COUNT_MAX) over = 1'b1;
        if (req_r.direction && cur_row[i] == '0) under = 1'b1;
        new_row[i] = req_r.direction ? cur_row[i] - 1'b1 : cur_row[i] + 1'b1;
      end
    end

    bus_count = rcgt_pkg::DOM_W'(rcgt_pkg::DOMAINS_PER_BUS);
    if (req_r.bus_select < rcgt_pkg::BUS_W'(rcgt_pkg::NUM_REGS)) begin
      bus_count = domains_r[req_r.bus_select];
    end
    bus_valid = rcgt_pkg::valid_mask(bus_count);

    if (!bus_ok)                                err = rcgt_pkg::ERR_BUS;
    else if ((req_r.domain_mask & ~bus_valid) != '0) err = rcgt_pkg::ERR_RANGE;
    else if (over)                              err = rcgt_pkg::ERR_OVER;
    else if (under)                             err = rcgt_pkg::ERR_UNDER;
    else                                        err = rcgt_pkg::ERR_OK;

    en_mask = '0;
    for (int i = 0; i < rcgt_pkg::DOMAINS_PER_BUS; i++) begin
      en_mask[i] = (err == rcgt_pkg::ERR_OK) ? (new_row[i] != '0) : (cur_row[i] != '0);
    end
  end

  assign mem_we = busy && (err == rcgt_pkg::ERR_OK);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      out_word_r.bus_echo          <= req_r.bus_select;
      out_word_r.clock_enable_mask <= en_mask;
      out_word_r.error_code        <= err;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Assertions
  `ASSERT_NEXT(a_accept_enters_update, clk, rst_n, accept, busy)
  `ASSERT_NEXT(a_update_one_cycle, clk, rst_n, busy, out_strobe && !busy)
  `ASSERT_NOW(a_bad_bus_no_enable, clk, rst_n, out_strobe && out_word.error_code == rcgt_pkg::ERR_BUS, out_word.clock_enable_mask == '0)
  `ASSERT_NOW(a_no_write_on_error, clk, rst_n, mem_we, busy && bus_ok)

endmodule
